@@ hdl/eshc_pkg.sv @@
// ----------------------------------------------------------------------------
// eshc_pkg
// Types and constants shared by the edge set hash cache modules.
// ----------------------------------------------------------------------------
package eshc_pkg;

   localparam int CFG_W = 11;
   localparam int VAL_W = 32;
   localparam int KEY_W = 64;
   localparam int NODE_W = 8;
   localparam int COLOR_W = 2;
   localparam int OUTCOME_W = 3;
   localparam int STEP_W = 2;

   localparam logic [KEY_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
   // prime is 2^40 + 0x1b3
   localparam int FNV_SHIFT = 40;
   localparam logic [8:0] FNV_LOW = 9'h1B3;
   localparam logic [CFG_W-1:0] COUNT_MAX = 11'h7FF;
   localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd768;
   localparam logic [STEP_W-1:0] STEP_LAST = 2'd2;
   localparam logic [STEP_W-1:0] STEP_U = 2'd0;
   localparam logic [STEP_W-1:0] STEP_V = 2'd1;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_HIT = 3'd0,
      OUT_MISS = 3'd1,
      OUT_INSERTED = 3'd2,
      OUT_UPDATED = 3'd3,
      OUT_FULL = 3'd4,
      OUT_EXHAUSTED = 3'd5,
      OUT_EMPTY = 3'd6
   } outcome_type;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE = 8'b0000_0010,
      ST_MUL = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_READ = 8'b0001_0000,
      ST_CHECK = 8'b0010_0000,
      ST_OUT = 8'b0100_0000
   } state_type;

   typedef struct packed {
      logic clr_en;
      logic take;
      logic mul_en;
      logic decide_en;
      logic rd_en;
      logic chk_en;
      logic out_en;
   } cmd_type;

   typedef struct packed {
      logic in_live;
      logic in_last;
      logic item_last;
      logic mul_last;
      logic early_exit;
      logic chk_done;
      logic clr_last;
      logic rsp_free;
   } status_type;

endpackage

@@ hdl/eshc_if.sv @@
// ----------------------------------------------------------------------------
// eshc request and response channels
// Valid/ready channels carrying one edge item and one result item.
// ----------------------------------------------------------------------------
interface eshc_req_if;
   logic valid;
   logic ready;
   logic [0:0] opcode;
   logic [0:0] edge_live;
   logic [7:0] node_u;
   logic [7:0] node_v;
   logic [1:0] edge_color;
   logic [31:0] entry_value;
   logic [0:0] last_edge;

   modport source (output valid, opcode, edge_live, node_u, node_v, edge_color,
      entry_value, last_edge, input ready);
   modport sink (input valid, opcode, edge_live, node_u, node_v, edge_color,
      entry_value, last_edge, output ready);
endinterface

interface eshc_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] outcome;
   logic [31:0] hit_value;

   modport source (output valid, outcome, hit_value, input ready);
   modport sink (input valid, outcome, hit_value, output ready);
endinterface

@@ hdl/eshc_ram.sv @@
// ----------------------------------------------------------------------------
// eshc_ram
// Generic simple dual port RAM with registered read.
// ----------------------------------------------------------------------------
module eshc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/eshc_ctrl.sv @@
// ----------------------------------------------------------------------------
// eshc_ctrl
// Sequencer for clearing, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
module eshc_ctrl import eshc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  status_type status,
   output cmd_type cmd,
   output logic req_ready
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.in_live) begin
                  state_in = ST_MUL;
               end else if (status.in_last) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (status.mul_last) begin
               state_in = status.item_last ? ST_DECIDE : ST_IDLE;
            end
         end
         ST_DECIDE: begin
            cmd.decide_en = 1'b1;
            state_in = status.early_exit ? ST_OUT : ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.chk_en = 1'b1;
            state_in = status.chk_done ? ST_OUT : ST_READ;
         end
         ST_OUT: begin
            cmd.out_en = 1'b1;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

@@ hdl/eshc_dp.sv @@
// ----------------------------------------------------------------------------
// eshc_dp
// Hash datapath, probe addressing, slot table and result register.
// ----------------------------------------------------------------------------
module eshc_dp import eshc_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_SLOTS = 8
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output status_type status,
   input  logic csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic [0:0] in_opcode,
   input  logic [0:0] in_live,
   input  logic [NODE_W-1:0] in_u,
   input  logic [NODE_W-1:0] in_v,
   input  logic [COLOR_W-1:0] in_color,
   input  logic [VAL_W-1:0] in_value,
   input  logic [0:0] in_last,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic [VAL_W-1:0] rsp_hit_value
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PW = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;
   localparam int SW = IDX_W + PW;
   localparam int ROW_W = 1 + KEY_W + VAL_W;
   localparam logic [SW-1:0] MASK = SW'(TABLE_DEPTH - 1);
   localparam logic [PW-1:0] PROBE_END = PW'(PROBE_SLOTS - 1);
   localparam logic [IDX_W-1:0] IDX_END = IDX_W'(TABLE_DEPTH - 1);

   logic [0:0] op_ff;
   logic [NODE_W-1:0] u_ff, v_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [VAL_W-1:0] value_ff;
   logic last_ff;
   logic [KEY_W-1:0] hash_ff, hash_in, key_ff, mul_x;
   logic any_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PW-1:0] probe_ff;
   logic [IDX_W-1:0] addr_ff, probe_addr, clr_ff;
   logic [CFG_W-1:0] count_ff, max_ff;
   logic [OUTCOME_W-1:0] outcome_ff, chk_outcome;
   logic [VAL_W-1:0] hit_ff;
   logic rsp_valid_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic [VAL_W-1:0] rsp_hit_ff;
   logic [SW-1:0] probe_sum;
   logic full, empty, row_used, match, probe_last, chk_done, chk_write, out_load;
   logic [KEY_W-1:0] row_key;
   logic [VAL_W-1:0] row_val;
   logic [ROW_W-1:0] rd_row, wr_row;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;

   // hash step: xor a field, multiply by the prime
   always_comb begin
      case (step_ff)
         STEP_U: mul_x = hash_ff ^ KEY_W'(u_ff);
         STEP_V: mul_x = hash_ff ^ KEY_W'(v_ff);
         default: mul_x = hash_ff ^ KEY_W'(color_ff);
      endcase
      hash_in = (mul_x << FNV_SHIFT) + (mul_x * KEY_W'(FNV_LOW));
   end

   assign probe_sum = (SW'(key_ff[IDX_W-1:0]) & MASK) + SW'(probe_ff);
   assign probe_addr = IDX_W'(probe_sum & MASK);

   assign full = (op_ff == 1'b1) && (count_ff >= max_ff);
   assign empty = !any_ff;

   assign row_used = rd_row[ROW_W-1];
   assign row_key = rd_row[VAL_W +: KEY_W];
   assign row_val = rd_row[VAL_W-1:0];
   assign match = row_used && (row_key == key_ff);
   assign probe_last = (probe_ff == PROBE_END);
   assign chk_done = !row_used || match || probe_last;
   assign chk_write = (op_ff == 1'b1) && (match || !row_used);

   always_comb begin
      if (op_ff == 1'b0) begin
         chk_outcome = match ? OUT_HIT : OUT_MISS;
      end else if (match) begin
         chk_outcome = OUT_UPDATED;
      end else if (!row_used) begin
         chk_outcome = OUT_INSERTED;
      end else begin
         chk_outcome = OUT_EXHAUSTED;
      end
   end

   assign out_load = cmd.out_en && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      wr_en = cmd.clr_en || (cmd.chk_en && chk_write);
      wr_addr = cmd.clr_en ? clr_ff : addr_ff;
      wr_row = cmd.clr_en ? '0 : {1'b1, key_ff, value_ff};
   end

   eshc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(TABLE_DEPTH)
   ) u_slots (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_en(cmd.rd_en),
      .rd_addr(probe_addr),
      .rd_data(rd_row)
   );

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff <= in_opcode;
         u_ff <= in_u;
         v_ff <= in_v;
         color_ff <= in_color;
         value_ff <= in_value;
         last_ff <= in_last[0];
      end
      if (cmd.rd_en) begin
         addr_ff <= probe_addr;
      end
      if (cmd.decide_en) begin
         outcome_ff <= full ? OUT_FULL : OUT_EMPTY;
         hit_ff <= '0;
      end
      if (cmd.chk_en && chk_done) begin
         outcome_ff <= chk_outcome;
         hit_ff <= ((op_ff == 1'b0) && match) ? row_val : '0;
      end
      if (out_load) begin
         rsp_outcome_ff <= outcome_ff;
         rsp_hit_ff <= hit_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         key_ff <= '0;
         any_ff <= 1'b0;
         step_ff <= '0;
         probe_ff <= '0;
         clr_ff <= '0;
         count_ff <= '0;
         max_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.take) begin
            step_ff <= '0;
         end
         if (cmd.mul_en) begin
            hash_ff <= hash_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               key_ff <= key_ff ^ hash_in;
               any_ff <= 1'b1;
            end
         end
         if (cmd.decide_en) begin
            probe_ff <= '0;
         end
         if (cmd.chk_en) begin
            if (!chk_done) begin
               probe_ff <= probe_ff + 1'b1;
            end else if ((op_ff == 1'b1) && !row_used && (count_ff != COUNT_MAX)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (out_load) begin
            hash_ff <= FNV_BASIS;
            key_ff <= '0;
            any_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.in_live = in_live[0];
      status.in_last = in_last[0];
      status.item_last = last_ff;
      status.mul_last = (step_ff == STEP_LAST);
      status.early_exit = full || empty;
      status.chk_done = chk_done;
      status.clr_last = (clr_ff == IDX_END);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_hit_value = rsp_hit_ff;

`ifndef SYNTHESIS
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff >= $past(count_ff)))
      else $error("entry count went down");
   a_hit_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_hit_ff != '0)) |-> (rsp_outcome_ff == OUT_HIT))
      else $error("nonzero hit value without a hit");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.chk_en |-> (probe_ff <= PROBE_END))
      else $error("probe walk past its limit");
`endif

endmodule

@@ hdl/edge_set_hash_cache.sv @@
// ----------------------------------------------------------------------------
// edge_set_hash_cache
// Memo table keyed by a hash of a set of graph edges, linear probing.
//
//   channel   dir   handshake        carries
//   req_ch    in    valid/ready      one edge item per transfer
//   rsp_ch    out   valid/ready      one result item per request
//   csr_*     in    write enable     entry limit register
//
// A live edge is accepted and then runs through the hash multiplier; a dead
// edge is only accepted. The last edge adds a decide step, a RAM read and a
// compare per probed slot, and a step to hand off the result.
// After reset a clearing pass over every slot runs before the first item.
// A stalled result holds in its register; edges of the next request are taken.
// ----------------------------------------------------------------------------
module edge_set_hash_cache import eshc_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_SLOTS = 8
) (
   input  logic clock,
   input  logic reset,
   eshc_req_if.sink req_ch,
   eshc_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   cmd_type cmd;
   status_type status;
   logic rsp_valid;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [VAL_W-1:0] rsp_hit_value;

   eshc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .status(status),
      .cmd(cmd),
      .req_ready(req_ch.ready)
   );

   eshc_dp #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PROBE_SLOTS(PROBE_SLOTS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .in_opcode(req_ch.opcode),
      .in_live(req_ch.edge_live),
      .in_u(req_ch.node_u),
      .in_v(req_ch.node_v),
      .in_color(req_ch.edge_color),
      .in_value(req_ch.entry_value),
      .in_last(req_ch.last_edge),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_valid),
      .rsp_outcome(rsp_outcome),
      .rsp_hit_value(rsp_hit_value)
   );

   assign rsp_ch.valid = rsp_valid;
   assign rsp_ch.outcome = rsp_outcome;
   assign rsp_ch.hit_value = rsp_hit_value;

endmodule
